[hdl/slcd_pkg.sv]
`default_nettype none

package slcd_pkg;

  localparam logic [15:0] SYNC_WORD       = 16'h4FFF;
  localparam logic [8:0]  MAX_PAYLOAD_RST = 9'd505;
  localparam int          CHANNELS_DEF    = 4;

  localparam int CH_W     = 2;
  localparam int WORD_W   = 16;
  localparam int IDX_W    = 9;
  localparam int BYTES_W  = 10;
  localparam int TDATA_W  = 40;
  localparam int TUSER_W  = 3;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_SUMA = 3'd2,
    PH_SUMB = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_LEN = 2'd2
  } status_t;

  typedef struct packed {
    phase_t              phase;
    logic [IDX_W-1:0]    len;
    logic [IDX_W-1:0]    pos;
    logic [WORD_W-1:0]   exp_a;
    logic [WORD_W-1:0]   exp_b;
    logic [WORD_W-1:0]   run_a;
    logic [WORD_W-1:0]   run_b;
  } chst_t;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [WORD_W-1:0]   word;
    logic [IDX_W-1:0]    idx;
    logic                has;
    logic                last;
    status_t             st;
    logic [BYTES_W-1:0]  bytes;
  } res_t;

endpackage

`default_nettype wire

[hdl/slcd_in_reg.sv]
`default_nettype none

module slcd_in_reg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [slcd_pkg::WORD_W-1:0] in_tdata,
  input  wire logic [slcd_pkg::CH_W-1:0]   in_tuser,
  input  wire logic                       adv,
  output logic                            v,
  output logic [slcd_pkg::CH_W-1:0]       ch,
  output logic [slcd_pkg::WORD_W-1:0]     word
);

  logic                          v_r, v_nxt;
  logic [slcd_pkg::CH_W-1:0]     ch_r;
  logic [slcd_pkg::WORD_W-1:0]   word_r;
  logic                          take;

  assign in_tready = !v_r || adv;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    v_nxt = v_r;
    if (take) begin
      v_nxt = 1'b1;
    end else if (adv) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ch_r   <= in_tuser;
      word_r <= in_tdata;
    end
  end

  assign v    = v_r;
  assign ch   = ch_r;
  assign word = word_r;

endmodule

`default_nettype wire

[hdl/slcd_core.sv]
`default_nettype none

module slcd_core #(
  parameter int CHANNELS = slcd_pkg::CHANNELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [slcd_pkg::CH_W-1:0]   ch,
  input  wire logic [slcd_pkg::WORD_W-1:0] word,
  input  wire logic [slcd_pkg::IDX_W-1:0]  max_words,
  output logic                             res_v,
  output slcd_pkg::res_t                   res
);

  slcd_pkg::chst_t  st_r [CHANNELS];
  slcd_pkg::chst_t  cur;
  slcd_pkg::chst_t  nxt;
  slcd_pkg::phase_t phase_nxt;
  logic             hit;
  logic             too_big;
  logic             is_sync;
  logic             last;
  logic [slcd_pkg::IDX_W:0]      pos1;
  logic [25:0]                   prod;
  logic [slcd_pkg::WORD_W-1:0]   p;
  logic [slcd_pkg::WORD_W-1:0]   sum_a;
  logic [slcd_pkg::WORD_W-1:0]   sum_b;
  logic [slcd_pkg::WORD_W-1:0]   init_a;

  // channel lookup; out-of-range channels miss
  always_comb begin
    cur = '0;
    hit = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(ch) == i) begin
        cur = st_r[i];
        hit = 1'b1;
      end
    end
  end

  assign too_big = word > {7'd0, max_words};
  assign is_sync = word == slcd_pkg::SYNC_WORD;
  assign pos1    = {1'b0, cur.pos} + 10'd1;
  assign prod    = word * pos1;
  assign p       = prod[15:0];
  assign sum_a   = cur.run_a + p;
  assign sum_b   = cur.run_b + ~p;
  assign last    = pos1 >= {1'b0, cur.len};
  assign init_a  = slcd_pkg::SYNC_WORD + {7'd0, cur.len};

  // next phase
  always_comb begin
    unique case (cur.phase)
      slcd_pkg::PH_LEN: begin
        if (too_big) begin
          phase_nxt = is_sync ? slcd_pkg::PH_LEN : slcd_pkg::PH_HUNT;
        end else begin
          phase_nxt = slcd_pkg::PH_SUMA;
        end
      end
      slcd_pkg::PH_SUMA: phase_nxt = slcd_pkg::PH_SUMB;
      slcd_pkg::PH_SUMB: begin
        phase_nxt = (cur.len == '0) ? slcd_pkg::PH_HUNT : slcd_pkg::PH_DATA;
      end
      slcd_pkg::PH_DATA: phase_nxt = last ? slcd_pkg::PH_HUNT : slcd_pkg::PH_DATA;
      default:           phase_nxt = is_sync ? slcd_pkg::PH_LEN : slcd_pkg::PH_HUNT;
    endcase
  end

  // datapath and result
  always_comb begin
    nxt       = cur;
    nxt.phase = phase_nxt;
    res       = '0;
    res.ch    = ch;
    res.st    = slcd_pkg::ST_OK;
    res_v     = 1'b0;
    unique case (cur.phase)
      slcd_pkg::PH_LEN: begin
        if (too_big) begin
          res_v    = 1'b1;
          res.last = 1'b1;
          res.st   = slcd_pkg::ST_BAD_LEN;
        end else begin
          nxt.len = word[slcd_pkg::IDX_W-1:0];
          nxt.pos = '0;
        end
      end
      slcd_pkg::PH_SUMA: nxt.exp_a = word;
      slcd_pkg::PH_SUMB: begin
        nxt.exp_b = word;
        nxt.run_a = init_a;
        nxt.run_b = '0;
        nxt.pos   = '0;
        if (cur.len == '0) begin
          res_v    = 1'b1;
          res.last = 1'b1;
          res.st   = (init_a == cur.exp_a && word == '0) ?
                     slcd_pkg::ST_OK : slcd_pkg::ST_BAD_SUM;
        end
      end
      slcd_pkg::PH_DATA: begin
        nxt.run_a = sum_a;
        nxt.run_b = sum_b;
        res_v     = 1'b1;
        res.word  = word;
        res.idx   = cur.pos;
        res.has   = 1'b1;
        if (last) begin
          res.last = 1'b1;
          if (sum_a == cur.exp_a && sum_b == cur.exp_b) begin
            res.bytes = {cur.len, 1'b0};
          end else begin
            res.st = slcd_pkg::ST_BAD_SUM;
          end
        end else begin
          nxt.pos = pos1[slcd_pkg::IDX_W-1:0];
        end
      end
      default: ;
    endcase
    if (!hit) begin
      res_v = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_r[i] <= '0;
      end
    end else if (step && hit) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (int'(ch) == i) begin
          st_r[i] <= nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/slcd_out_reg.sv]
`default_nettype none

module slcd_out_reg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           load,
  input  wire logic                           res_v,
  input  wire slcd_pkg::res_t                 res,
  output logic                                stall,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [slcd_pkg::TDATA_W-1:0]        out_tdata,
  output logic                                out_tlast,
  output logic [slcd_pkg::TUSER_W-1:0]        out_tuser
);

  logic           v_r, v_nxt;
  slcd_pkg::res_t res_r;

  assign stall = v_r && !out_tready;

  always_comb begin
    v_nxt = v_r && !out_tready;
    if (load) begin
      v_nxt = res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_v) begin
      res_r <= res;
    end
  end

  assign out_tvalid = v_r;
  assign out_tdata  = {3'd0, res_r.bytes, res_r.st, res_r.idx, res_r.word};
  assign out_tlast  = res_r.last;
  assign out_tuser  = {res_r.has, res_r.ch};

endmodule

`default_nettype wire

[hdl/sync_length_checksum_deframer_core.sv]
`default_nettype none

// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+---------------------------------------------
// in_      | in  | in_tvalid/in_tready  | tdata: rx_word; tuser: channel
// out_     | out | out_tvalid/out_tready| tdata/tuser/tlast: payload word or status
// cfg_     | in  | cfg_we               | cfg_wdata: max_payload_words
//
// One input transfer per cycle unless out_ stalls. A result, for input words that yield one,
// passes the input register, then the per-channel update into the result register.
// The 16x10 multiply-add and checksum compare between the registers set the clock period.
// Synchronous active-low reset returns every channel to sync hunt, limit to 505.
// Output stall holds the result register and, behind it, the input register.

module sync_length_checksum_deframer_core #(
  parameter int CHANNELS = slcd_pkg::CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [slcd_pkg::WORD_W-1:0]   in_tdata,  // [15:0] rx_word
  input  wire logic [slcd_pkg::CH_W-1:0]     in_tuser,  // [1:0] channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [15:0] payload_word, [24:16] payload_index, [26:25] status,
  // [36:27] byte_count, [39:37] zero
  output logic [slcd_pkg::TDATA_W-1:0]       out_tdata,
  output logic                               out_tlast, // packet_end
  output logic [slcd_pkg::TUSER_W-1:0]       out_tuser, // [1:0] out_channel, [2] has_payload
  input  wire logic                          cfg_we,
  input  wire logic [slcd_pkg::IDX_W-1:0]    cfg_wdata
);

  logic [slcd_pkg::IDX_W-1:0]  max_r;
  logic                        in_v;
  logic [slcd_pkg::CH_W-1:0]   in_ch;
  logic [slcd_pkg::WORD_W-1:0] in_word;
  logic                        adv;
  logic                        stall;
  logic                        res_v;
  slcd_pkg::res_t              res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= slcd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_r <= cfg_wdata;
    end
  end

  assign adv = in_v && !stall;

  slcd_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .adv       (adv),
    .v         (in_v),
    .ch        (in_ch),
    .word      (in_word)
  );

  slcd_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .ch        (in_ch),
    .word      (in_word),
    .max_words (max_r),
    .res_v     (res_v),
    .res       (res)
  );

  slcd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .res_v      (res_v),
    .res        (res),
    .stall      (stall),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

[hdl/slcd_chk.sv]
`default_nettype none

module slcd_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [slcd_pkg::TDATA_W-1:0]  out_tdata,
  input wire logic                          out_tlast,
  input wire logic [slcd_pkg::TUSER_W-1:0]  out_tuser
);

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26:25] != 2'd0 |-> out_tlast)
    else $error("error status without packet end");

  a_bytes_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[36:27] != 10'd0 |-> out_tlast && out_tdata[26:25] == 2'd0)
    else $error("byte count on non-final or failed packet");

  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tlast && out_tdata[24:0] == 25'd0)
    else $error("status-only result with payload fields set");

endmodule

bind sync_length_checksum_deframer_core slcd_chk u_slcd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

[test/sync_length_checksum_deframer_core_tb.sv]
`default_nettype none

module sync_length_checksum_deframer_core_tb;
  import slcd_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam int SETTLE = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 9;

  typedef struct {
    logic [CH_W-1:0]   ch;
    logic [WORD_W-1:0] w;
  } rx_item_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [WORD_W-1:0] in_tdata = '0;
  logic [CH_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic [TUSER_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_wdata = '0;

  sync_length_checksum_deframer_core #(.CHANNELS(NCH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // per-channel deframer state mirrored from the spec
  logic [IDX_W-1:0] max_words;
  phase_t           ch_phase [NCH];
  logic [IDX_W-1:0] ch_len   [NCH];
  logic [IDX_W-1:0] ch_pos   [NCH];
  logic [WORD_W-1:0] ch_exp_a[NCH];
  logic [WORD_W-1:0] ch_exp_b[NCH];
  logic [WORD_W-1:0] ch_run_a[NCH];
  logic [WORD_W-1:0] ch_run_b[NCH];

  res_t expected_results[$];
  rx_item_t rx_pending[$];
  logic [WORD_W-1:0] chan_words[NCH][$];

  bit gaps_on = 1'b0;
  int errors = 0;
  int words_in = 0;
  int results_seen = 0;
  int pk_ok = 0, pk_bad_sum = 0, pk_bad_len = 0;
  int send_gap = 0;
  int stall_left = 0;
  int quiet = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 40)
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  // advance one channel by one received word, queue any result it produces
  function automatic void track_word(input logic [CH_W-1:0] c, input logic [WORD_W-1:0] w);
    res_t r;
    logic [31:0] prod;
    logic [WORD_W-1:0] p;
    logic [IDX_W-1:0] pos;
    bit produce;
    r = '0;
    r.ch = c;
    produce = 1'b0;
    case (ch_phase[c])
      PH_LEN: begin
        if (w > 16'(max_words)) begin
          r.last = 1'b1;
          r.st = ST_BAD_LEN;
          produce = 1'b1;
          ch_phase[c] = (w == SYNC_WORD) ? PH_LEN : PH_HUNT;
        end else begin
          ch_len[c] = w[IDX_W-1:0];
          ch_pos[c] = '0;
          ch_phase[c] = PH_SUMA;
        end
      end
      PH_SUMA: begin
        ch_exp_a[c] = w;
        ch_phase[c] = PH_SUMB;
      end
      PH_SUMB: begin
        ch_exp_b[c] = w;
        ch_run_a[c] = SYNC_WORD + 16'(ch_len[c]);
        ch_run_b[c] = '0;
        ch_pos[c] = '0;
        if (ch_len[c] == '0) begin
          r.last = 1'b1;
          r.st = (ch_run_a[c] == ch_exp_a[c] && ch_run_b[c] == ch_exp_b[c]) ? ST_OK : ST_BAD_SUM;
          produce = 1'b1;
          ch_phase[c] = PH_HUNT;
        end else begin
          ch_phase[c] = PH_DATA;
        end
      end
      PH_DATA: begin
        pos = ch_pos[c];
        prod = {16'd0, w} * (32'(pos) + 32'd1);
        p = prod[15:0];
        ch_run_a[c] = ch_run_a[c] + p;
        ch_run_b[c] = ch_run_b[c] + ~p;
        r.word = w;
        r.idx = pos;
        r.has = 1'b1;
        produce = 1'b1;
        if (32'(pos) + 32'd1 >= 32'(ch_len[c])) begin
          r.last = 1'b1;
          r.st = (ch_run_a[c] == ch_exp_a[c] && ch_run_b[c] == ch_exp_b[c]) ? ST_OK : ST_BAD_SUM;
          r.bytes = (r.st == ST_OK) ? {ch_len[c], 1'b0} : '0;
          ch_phase[c] = PH_HUNT;
        end else begin
          ch_pos[c] = pos + 9'd1;
        end
      end
      default: begin
        ch_phase[c] = (w == SYNC_WORD) ? PH_LEN : PH_HUNT;
      end
    endcase
    if (produce) begin
      if (r.last) begin
        if (r.st == ST_OK) pk_ok++;
        else if (r.st == ST_BAD_SUM) pk_bad_sum++;
        else pk_bad_len++;
      end
      expected_results.push_back(r);
    end
  endfunction

  // input side: drains rx_pending, predicts every accepted transfer
  always @(posedge clk) begin : drive
    rx_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_word(in_tuser, in_tdata);
        words_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          nxt = rx_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.ch;
          in_tdata <= nxt.w;
          send_gap = gaps_on ? draw_gap() : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: random backpressure and field-by-field check
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, tdata", out_tdata, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser[1:0] != want.ch)   report_mismatch("out_channel", out_tuser[1:0], want.ch);
          if (out_tdata[15:0] != want.word) report_mismatch("payload_word", out_tdata[15:0], want.word);
          if (out_tdata[24:16] != want.idx) report_mismatch("payload_index", out_tdata[24:16], want.idx);
          if (out_tuser[2] != want.has)    report_mismatch("has_payload", out_tuser[2], want.has);
          if (out_tlast != want.last)      report_mismatch("packet_end", out_tlast, want.last);
          if (out_tdata[26:25] != want.st) report_mismatch("status", out_tdata[26:25], want.st);
          if (out_tdata[36:27] != want.bytes)
            report_mismatch("byte_count", out_tdata[36:27], want.bytes);
          if (out_tdata[39:37] != 3'd0)    report_mismatch("tdata pad", out_tdata[39:37], 0);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (gaps_on && $urandom_range(0, 2) == 0) stall_left = draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (max_words == 0) return 0;
    if (r < 60) return $urandom_range(0, (max_words < 6) ? max_words : 6);
    if (r < 90) return $urandom_range(0, (max_words < 40) ? max_words : 40);
    if (r < 99) return $urandom_range(0, (max_words < 100) ? max_words : 100);
    return max_words;
  endfunction

  function automatic logic [WORD_W-1:0] pick_payload();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'hFFFF;
    if (r == 1) return 16'h0000;
    return 16'($urandom);
  endfunction

  // well-formed packet (optionally with a damaged checksum word) on one channel
  task automatic add_packet(input int c, input int len, input bit corrupt);
    logic [WORD_W-1:0] sa, sb, w;
    logic [31:0] prod;
    logic [WORD_W-1:0] body[$];
    sa = SYNC_WORD + 16'(len);
    sb = '0;
    for (int i = 0; i < len; i++) begin
      w = pick_payload();
      prod = {16'd0, w} * 32'(i + 1);
      sa += prod[15:0];
      sb += ~prod[15:0];
      body.push_back(w);
    end
    if (corrupt) begin
      if ($urandom_range(0, 1) == 1) sa ^= 16'(1 << $urandom_range(0, 15));
      else sb ^= 16'(1 << $urandom_range(0, 15));
    end
    chan_words[c].push_back(SYNC_WORD);
    chan_words[c].push_back(16'(len));
    chan_words[c].push_back(sa);
    chan_words[c].push_back(sb);
    foreach (body[i]) chan_words[c].push_back(body[i]);
  endtask

  function automatic logic [WORD_W-1:0] pick_oversize();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return SYNC_WORD;
    if (r < 40) return 16'hFFFF;
    if (r < 55) return 16'(max_words) + 16'd1;
    return 16'($urandom_range(int'(max_words) + 1, 65535));
  endfunction

  function automatic int words_queued();
    int n;
    n = 0;
    for (int c = 0; c < NCH; c++) n += chan_words[c].size();
    return n;
  endfunction

  task automatic fill_phase(input int target);
    int c, kind, n;
    rx_item_t it;
    while (words_queued() < target) begin
      c = $urandom_range(0, NCH - 1);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        add_packet(c, pick_len(), 1'b0);
      end else if (kind < 80) begin
        add_packet(c, pick_len(), 1'b1);
      end else if (kind < 88) begin
        chan_words[c].push_back(SYNC_WORD);
        chan_words[c].push_back(pick_oversize());
      end else if (kind < 95) begin
        n = $urandom_range(1, 3);
        repeat (n) chan_words[c].push_back(($urandom_range(0, 4) == 0) ? SYNC_WORD : 16'($urandom));
      end else begin
        // header cut short: following words land in the checksum and payload slots
        chan_words[c].push_back(SYNC_WORD);
        chan_words[c].push_back(16'(pick_len()));
        chan_words[c].push_back(16'($urandom));
      end
    end
    while (words_queued() > 0) begin
      c = $urandom_range(0, NCH - 1);
      if (chan_words[c].size() > 0) begin
        it.ch = CH_W'(c);
        it.w = chan_words[c].pop_front();
        rx_pending.push_back(it);
      end
    end
  endtask

  // sampled mid-cycle so the driver's updates at the edge are already visible
  task automatic wait_idle();
    @(negedge clk);
    while (rx_pending.size() > 0 || in_tvalid || expected_results.size() > 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    int limits[PHASES];
    limits = '{505, 0, 1, 511, 2, 0, 505, 7, 300};
    limits[5] = $urandom_range(3, 504);
    max_words = MAX_PAYLOAD_RST;
    for (int c = 0; c < NCH; c++) begin
      ch_phase[c] = PH_HUNT;
      ch_len[c] = '0;
      ch_pos[c] = '0;
      ch_exp_a[c] = '0;
      ch_exp_b[c] = '0;
      ch_run_a[c] = '0;
      ch_run_b[c] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph > 0) begin
        cfg_we <= 1'b1;
        cfg_wdata <= IDX_W'(limits[ph]);
        max_words = IDX_W'(limits[ph]);
        @(posedge clk);
        cfg_we <= 1'b0;
        gaps_on = ($urandom_range(0, 3) != 0);
      end else begin
        gaps_on = 1'b1;
        // zero-length packet, good checksums
        add_packet(0, 0, 1'b0);
        // length one above the limit, then sync word as length, then recovery
        chan_words[1].push_back(SYNC_WORD);
        chan_words[1].push_back(16'd506);
        chan_words[1].push_back(SYNC_WORD);
        chan_words[1].push_back(SYNC_WORD);
        add_packet(1, 1, 1'b0);
        add_packet(2, 3, 1'b1);
        chan_words[3].push_back(16'hFFFF);
        chan_words[3].push_back(16'h0000);
        add_packet(3, 0, 1'b1);
        chan_words[3].push_back(SYNC_WORD);
        chan_words[3].push_back(16'hFFFF);
      end
      fill_phase(180);
    end

    wait_idle();
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    $display("covered %0d input transfers and %0d result transfers over %0d limit settings",
             words_in, results_seen, PHASES);
    $display("packets ended: %0d ok, %0d checksum mismatch, %0d length too large",
             pk_ok, pk_bad_sum, pk_bad_len);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hdl/slcd_pkg.sv
hdl/slcd_in_reg.sv
hdl/slcd_core.sv
hdl/slcd_out_reg.sv
hdl/sync_length_checksum_deframer_core.sv
hdl/slcd_chk.sv
test/sync_length_checksum_deframer_core_tb.sv
